@@ rtl/sha1_pkg.sv @@
// shared types and constants for the sha-1 hash block
`default_nettype none
package sha1_pkg;

  typedef logic [4:0][31:0] cv_arr_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
  } fill_req_t;

  // initial hash values, index 0 is h0
  localparam cv_arr_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                            32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0] SCHED_START = 7'd16;
  localparam logic [6:0] LAST_ROUND  = 7'd79;

endpackage
`default_nettype wire

@@ rtl/sha1_cmp.sv @@
// sha-1 compression engine around a 16-word schedule memory
`default_nettype none
module sha1_cmp import sha1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fill_req_t fill_i,
  input  logic      start_i,
  input  cv_arr_t   cv_i,
  output logic      busy_o,
  output logic      done_o,
  output cv_arr_t   wv_o
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_PH0  = 2'd1;
  localparam logic [1:0] C_PH1  = 2'd2;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    rotl1 = {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    rotl5 = {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    rotl30 = {x[1:0], x[31:2]};
  endfunction

  logic [1:0]  state_q, state_d;
  logic [6:0]  round_q, round_d;
  logic [6:0]  round_nx;
  cv_arr_t     v_q, v_d;
  logic [31:0] x_q, x_d;
  logic        done_q, done_d;

  logic [31:0] mem [16];
  logic [3:0]  ra, rb;
  logic [31:0] rd_a_q, rd_b_q;
  logic        mem_we;
  logic [3:0]  mem_wa;
  logic [31:0] mem_wd;
  logic        rnd_we;

  logic [31:0] w, f, k, tmp;

  // schedule word and round function for the current round
  always_comb begin
    if (round_q < SCHED_START) begin
      w = rd_b_q;
    end else begin
      w = rotl1(x_q ^ rd_a_q ^ rd_b_q);
    end
    if (round_q < 7'd20) begin
      f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
      k = K0;
    end else if (round_q < 7'd40) begin
      f = v_q[1] ^ v_q[2] ^ v_q[3];
      k = K1;
    end else if (round_q < 7'd60) begin
      f = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
      k = K2;
    end else begin
      f = v_q[1] ^ v_q[2] ^ v_q[3];
      k = K3;
    end
    tmp = rotl5(v_q[0]) + f + v_q[4] + k + w;
  end

  assign round_nx = round_q + 7'd1;

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    v_d     = v_q;
    x_d     = x_q;
    done_d  = 1'b0;
    rnd_we  = 1'b0;
    ra      = round_q[3:0] - 4'd3;
    rb      = round_q[3:0] - 4'd8;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          v_d     = cv_i;
          round_d = '0;
          ra      = 4'd0 - 4'd3;
          rb      = 4'd0 - 4'd8;
          state_d = C_PH0;
        end
      end
      C_PH0: begin
        x_d     = rd_a_q ^ rd_b_q;
        ra      = round_q[3:0] - 4'd14;
        rb      = round_q[3:0];
        state_d = C_PH1;
      end
      C_PH1: begin
        v_d[4] = v_q[3];
        v_d[3] = v_q[2];
        v_d[2] = rotl30(v_q[1]);
        v_d[1] = v_q[0];
        v_d[0] = tmp;
        rnd_we = (round_q >= SCHED_START);
        // next round reads t-2 and t-7, never the word written now
        ra     = round_nx[3:0] - 4'd3;
        rb     = round_nx[3:0] - 4'd8;
        if (round_q == LAST_ROUND) begin
          done_d  = 1'b1;
          state_d = C_IDLE;
        end else begin
          round_d = round_nx;
          state_d = C_PH0;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we = fill_i.en | rnd_we;
    if (rnd_we) begin
      mem_wa = round_q[3:0];
      mem_wd = w;
    end else begin
      mem_wa = fill_i.addr;
      mem_wd = fill_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      round_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    x_q <= x_d;
  end

  assign busy_o = (state_q != C_IDLE);
  assign done_o = done_q;
  assign wv_o   = v_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held longer than one cycle");

  a_fill_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_i.en |-> (state_q == C_IDLE))
    else $error("schedule fill while rounds are running");

  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_PH1 && round_q == LAST_ROUND) |=> (done_q && state_q == C_IDLE))
    else $error("last round did not finish the block");

endmodule
`default_nettype wire

@@ rtl/sha1_hash_top.sv @@
// sha-1 hash top level: byte packing, padding, chaining values, digest register
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_stall_o    data_byte_i, byte_valid_i, end_of_message_i
//   out      out  out_valid_o / out_stall_i  digest_h0_o .. digest_h4_o
//
// a byte is taken while in_stall_o is low; the 64th byte of a block starts
// the compression engine, which runs each of its 80 rounds as a ph0 then a
// ph1 state (schedule memory read twice per round over its two read ports).
// end of message adds padding writes before each of its one or two blocks,
// and a load of the digest register.
// reset loads the initial hash values; no clearing pass is needed.
// the digest waits in its register while out is stalled; the next request
// is only held off while a new digest cannot be loaded.
`default_nettype none
module sha1_hash_top import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_h0_o,
  output logic [31:0] digest_h1_o,
  output logic [31:0] digest_h2_o,
  output logic [31:0] digest_h3_o,
  output logic [31:0] digest_h4_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [60:0] count_q, count_d;
  logic [31:0] wbuf_q, wbuf_d;
  cv_arr_t     cv_q, cv_d;
  logic        fin_q, fin_d;
  logic        last_q, last_d;
  logic        two_q, two_d;
  logic        pad2_q, pad2_d;
  logic [4:0]  pad_idx_q, pad_idx_d;
  logic        out_valid_q, out_valid_d;
  cv_arr_t     out_q, out_d;

  logic [5:0]  pos;
  logic [31:0] part_word;
  logic [31:0] byte_word;
  logic [31:0] pad80_word;
  logic [63:0] bitlen;
  logic        in_acc;

  fill_req_t   fill;
  logic        cmp_start;
  logic        cmp_busy;
  logic        cmp_done;
  cv_arr_t     cmp_wv;

  sha1_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fill_i  (fill),
    .start_i (cmp_start),
    .cv_i    (cv_q),
    .busy_o  (cmp_busy),
    .done_o  (cmp_done),
    .wv_o    (cmp_wv)
  );

  assign pos        = count_q[5:0];
  // bytes already packed into the current word, big-endian
  assign part_word  = (pos[1:0] == 2'd0) ? 32'd0 : wbuf_q;
  assign byte_word  = part_word | ({24'd0, data_byte_i} << {~pos[1:0], 3'b000});
  assign pad80_word = part_word | (32'h0000_0080 << {~pos[1:0], 3'b000});
  assign bitlen     = {count_q, 3'b000};
  assign in_acc     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    wbuf_d      = wbuf_q;
    cv_d        = cv_q;
    fin_d       = fin_q;
    last_d      = last_q;
    two_d       = two_q;
    pad2_d      = pad2_q;
    pad_idx_d   = pad_idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    fill        = '0;
    cmp_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (byte_valid_i) begin
            wbuf_d  = byte_word;
            count_d = count_q + 61'd1;
            if (pos[1:0] == 2'd3) begin
              fill.en   = 1'b1;
              fill.addr = pos[5:2];
              fill.data = byte_word;
            end
            if (pos == 6'd63) begin
              cmp_start = 1'b1;
              fin_d     = end_of_message_i;
              state_d   = S_CMP;
            end else if (end_of_message_i) begin
              state_d = S_FIN;
            end
          end else if (end_of_message_i) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        fill.en   = 1'b1;
        fill.addr = pos[5:2];
        fill.data = pad80_word;
        pad_idx_d = {1'b0, pos[5:2]} + 5'd1;
        // no room for the length: pad out this block, then a second one
        two_d     = (pos[5:3] == 3'b111);
        fin_d     = 1'b0;
        state_d   = S_PAD;
      end
      S_PAD: begin
        if (two_q) begin
          if (pad_idx_q == 5'd16) begin
            cmp_start = 1'b1;
            two_d     = 1'b0;
            pad2_d    = 1'b1;
            state_d   = S_CMP;
          end else begin
            fill.en   = 1'b1;
            fill.addr = pad_idx_q[3:0];
            pad_idx_d = pad_idx_q + 5'd1;
          end
        end else begin
          fill.en   = 1'b1;
          fill.addr = pad_idx_q[3:0];
          pad_idx_d = pad_idx_q + 5'd1;
          if (pad_idx_q == 5'd15) begin
            fill.data = bitlen[31:0];
            cmp_start = 1'b1;
            last_d    = 1'b1;
            state_d   = S_CMP;
          end else if (pad_idx_q == 5'd14) begin
            fill.data = bitlen[63:32];
          end
        end
      end
      S_CMP: begin
        if (cmp_done) begin
          for (int i = 0; i < 5; i++) begin
            cv_d[i] = cv_q[i] + cmp_wv[i];
          end
          if (last_q) begin
            state_d = S_EMIT;
          end else if (pad2_q) begin
            pad2_d    = 1'b0;
            pad_idx_d = '0;
            state_d   = S_PAD;
          end else if (fin_q) begin
            state_d = S_FIN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = cv_q;
          out_valid_d = 1'b1;
          cv_d        = IV;
          count_d     = '0;
          last_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cv_q        <= IV;
      fin_q       <= 1'b0;
      last_q      <= 1'b0;
      two_q       <= 1'b0;
      pad2_q      <= 1'b0;
      pad_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cv_q        <= cv_d;
      fin_q       <= fin_d;
      last_q      <= last_d;
      two_q       <= two_d;
      pad2_q      <= pad2_d;
      pad_idx_q   <= pad_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wbuf_q <= wbuf_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign digest_h0_o = out_q[0];
  assign digest_h1_o = out_q[1];
  assign digest_h2_o = out_q[2];
  assign digest_h3_o = out_q[3];
  assign digest_h4_o = out_q[4];

  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && (!out_valid_q || !out_stall_i))
      |=> (out_valid_q && count_q == '0 && state_q == S_IDLE))
    else $error("digest load did not restart the message");

  a_busy_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_busy |-> (state_q == S_CMP))
    else $error("engine running outside the compress state");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled digest changed or dropped");

endmodule
`default_nettype wire
